// ===== rtl/lz77d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77d_pkg
// Shared constants, codes and length-code tables for the LZ77 bit-stream
// decompressor.
// ----------------------------------------------------------------------------
package lz77d_pkg;

    // Default sizing
    localparam int WINDOW_BITS_DEF = 21;
    localparam int LANE_BYTES_DEF  = 16;

    // Token format
    localparam int SLOT_BITS = 4;
    localparam int MIN_MATCH = 3;
    localparam int LANE_MAX  = 16;

    // Result error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DIST    = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_OUT_LENGTH = 1'b0;

    // Base value of each length class
    function automatic logic [9:0] len_base(input logic [2:0] cls);
        logic [9:0] r;
        unique case (cls)
            3'd0:    r = 10'd0;
            3'd1:    r = 10'd4;
            3'd2:    r = 10'd8;
            3'd3:    r = 10'd12;
            3'd4:    r = 10'd20;
            default: r = 10'd52;
        endcase
        return r;
    endfunction

    // Number of extra bits of each length class
    function automatic logic [4:0] len_width(input logic [2:0] cls);
        logic [4:0] r;
        unique case (cls)
            3'd0:    r = 5'd2;
            3'd1:    r = 5'd2;
            3'd2:    r = 5'd2;
            3'd3:    r = 5'd3;
            3'd4:    r = 5'd5;
            default: r = 5'd9;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lz77_bitstream_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_bitstream_decompressor_top
// LZ77 bit-stream decompressor: one compressed byte in, bytes out in lanes.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one compressed byte per transfer,
// with stream_start to begin a new stream. Output channel: out_valid /
// out_stall carry up to LANE_BYTES decoded bytes per transfer, the flags and
// an error code. out_length is written through the APB port at address 0.
// Each accepted byte is parsed twice: a first pass decodes tokens without
// touching the history memory to find where the stream stands after this
// byte (for stream_done), then a second pass redoes the parse and produces
// bytes. A match copy goes through the single history memory one byte at a
// time, with a read state followed by a write-back state for each byte.
// in_stall is high while a byte is being processed. When the receiver
// stalls, the output register holds and decoding waits for it to drain.
// Reset clears the parser, position, halt flag and out_length; the history
// memory is not cleared and is only read at addresses of the current stream.
// ----------------------------------------------------------------------------
module lz77_bitstream_decompressor_top #(
    parameter int WINDOW_BITS = lz77d_pkg::WINDOW_BITS_DEF,
    parameter int LANE_BYTES  = lz77d_pkg::LANE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  compressed_byte,
    input  logic        stream_start,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] bytes_low,
    output logic [63:0] bytes_high,
    output logic [4:0]  byte_count,
    output logic        last_of_run,
    output logic        stream_done,
    output logic [1:0]  error_code
);

    localparam int SLOT_BASE = WINDOW_BITS - 16;
    localparam int DIST_W    = WINDOW_BITS + 1;
    localparam int WIN_DEPTH = 1 << WINDOW_BITS;
    localparam logic [2:0] REG_OUT_LENGTH_ADDR = {lz77d_pkg::REG_OUT_LENGTH, 2'b00};

    typedef enum logic [3:0] {
        PH_FLAG    = 4'd0,
        PH_LIT     = 4'd1,
        PH_PRE0    = 4'd2,
        PH_PRE1    = 4'd3,
        PH_PRE2    = 4'd4,
        PH_PRE3    = 4'd5,
        PH_PRE4    = 4'd6,
        PH_LENBITS = 4'd7,
        PH_SLOT    = 4'd8,
        PH_OFFSET  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_COPY_RD,
        S_COPY_WR,
        S_FLUSH,
        S_FINAL,
        S_ERR_OUT
    } state_t;

    // Parser state and its snapshot at the start of a byte
    state_t      state_reg, ret_reg;
    phase_t      phase_reg, phase_snap_reg;
    logic [31:0] buf_reg, buf_snap_reg;
    logic [4:0]  cnt_reg, cnt_snap_reg;
    logic [9:0]  mlen_reg, mlen_snap_reg;
    logic [4:0]  olog_reg, olog_snap_reg;
    logic [30:0] pos_reg, pos_snap_reg;
    logic        halted_reg;
    logic        dry_reg;
    logic        done_reg;
    logic [1:0]  err_reg;
    logic [30:0] out_length_reg;

    // Match copy
    logic [10:0]        copy_left_reg;
    logic [DIST_W-1:0]  dist_reg;

    // Lane accumulator
    logic [7:0] acc_reg [lz77d_pkg::LANE_MAX];
    logic [4:0] acc_cnt_reg;
    logic       acc_full;

    // Output register
    logic        out_valid_reg;
    logic [63:0] lo_reg, hi_reg;
    logic [4:0]  oc_reg;
    logic        olast_reg, odone_reg;
    logic [1:0]  oerr_reg;
    logic        load_lanes;
    logic        load_any;

    // History memory
    logic [7:0]             hist_mem [WIN_DEPTH];
    logic                   mem_we;
    logic [WINDOW_BITS-1:0] mem_waddr;
    logic [7:0]             mem_wdata;
    logic                   mem_re;
    logic [WINDOW_BITS-1:0] mem_raddr;
    logic [7:0]             rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= hist_mem[mem_raddr];
        end
    end

    // Configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == REG_OUT_LENGTH_ADDR)
        begin
            prdata = {1'b0, out_length_reg};
        end
    end

    // Parse step decode
    logic [2:0]  len_cls;
    logic [4:0]  need;
    logic [31:0] field_v;
    logic        can_step;
    logic        out_free;
    logic [10:0] total;
    logic [DIST_W-1:0] off_v;
    logic [DIST_W-1:0] dist_v;
    logic [31:0] pos_ext;
    logic [2:0]  stage;

    assign len_cls = (olog_reg < 5'd6) ? olog_reg[2:0] : 3'd5;
    assign stage   = 3'(phase_reg - PH_PRE0);

    always_comb
    begin
        unique case (phase_reg)
            PH_FLAG:    need = 5'd1;
            PH_LIT:     need = 5'd8;
            PH_LENBITS: need = lz77d_pkg::len_width(len_cls);
            PH_SLOT:    need = 5'(lz77d_pkg::SLOT_BITS);
            PH_OFFSET:  need = (olog_reg > 5'(SLOT_BASE)) ? olog_reg : 5'(SLOT_BASE + 1);
            default:    need = 5'd1;
        endcase
    end

    assign field_v  = buf_reg & ((32'd1 << need) - 32'd1);
    assign can_step = (pos_reg < out_length_reg) && (err_reg == lz77d_pkg::ERR_NONE)
                      && (cnt_reg >= need);
    assign out_free = !out_valid_reg || !out_stall;
    assign total    = 11'(mlen_reg) + 11'(lz77d_pkg::MIN_MATCH);
    assign pos_ext  = {1'b0, pos_reg};
    assign acc_full = (acc_cnt_reg == 5'(LANE_BYTES));

    always_comb
    begin
        off_v = DIST_W'(field_v);
        if (olog_reg > 5'(SLOT_BASE))
        begin
            off_v = off_v + (DIST_W'(1) << olog_reg);
        end
        dist_v = off_v + DIST_W'(1);
    end

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg[WINDOW_BITS-1:0];
        mem_wdata = field_v[7:0];
        mem_re    = 1'b0;
        mem_raddr = WINDOW_BITS'(pos_reg - 31'(dist_reg));
        if (state_reg == S_DEC && !dry_reg && can_step && phase_reg == PH_LIT && !acc_full)
        begin
            mem_we = 1'b1;
        end
        if (state_reg == S_COPY_WR)
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_reg;
        end
        if (state_reg == S_COPY_RD && !acc_full)
        begin
            mem_re = 1'b1;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Output register load: a full lane set, the last lanes or an error result
    assign load_lanes = out_free && ((state_reg == S_FLUSH) ||
                        (state_reg == S_FINAL && acc_cnt_reg != 5'd0));
    assign load_any   = load_lanes || (out_free && state_reg == S_ERR_OUT);

    // Main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            phase_reg      <= PH_FLAG;
            phase_snap_reg <= PH_FLAG;
            buf_reg        <= 32'd0;
            buf_snap_reg   <= 32'd0;
            cnt_reg        <= 5'd0;
            cnt_snap_reg   <= 5'd0;
            mlen_reg       <= 10'd0;
            mlen_snap_reg  <= 10'd0;
            olog_reg       <= 5'd0;
            olog_snap_reg  <= 5'd0;
            pos_reg        <= 31'd0;
            pos_snap_reg   <= 31'd0;
            halted_reg     <= 1'b0;
            dry_reg        <= 1'b0;
            done_reg       <= 1'b0;
            err_reg        <= lz77d_pkg::ERR_NONE;
            out_length_reg <= 31'd0;
            acc_cnt_reg    <= 5'd0;
            for (int a = 0; a < lz77d_pkg::LANE_MAX; a++)
            begin
                acc_reg[a] <= 8'd0;
            end
            out_valid_reg  <= 1'b0;
            olast_reg      <= 1'b0;
            oerr_reg       <= lz77d_pkg::ERR_NONE;
            copy_left_reg  <= 11'd0;
            dist_reg       <= '0;
        end
        else
        begin
            if (cfg_wr && paddr == REG_OUT_LENGTH_ADDR)
            begin
                out_length_reg <= pwdata[30:0];
            end
            if (out_valid_reg && !out_stall && !load_any)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        logic        hlt;
                        logic [30:0] p;
                        logic [31:0] b;
                        logic [4:0]  c;
                        hlt = stream_start ? 1'b0 : halted_reg;
                        p   = stream_start ? 31'd0 : pos_reg;
                        b   = stream_start ? 32'd0 : buf_reg;
                        c   = stream_start ? 5'd0 : cnt_reg;
                        if (stream_start)
                        begin
                            phase_reg      <= PH_FLAG;
                            phase_snap_reg <= PH_FLAG;
                            mlen_reg       <= 10'd0;
                            mlen_snap_reg  <= 10'd0;
                            olog_reg       <= 5'd0;
                            olog_snap_reg  <= 5'd0;
                            pos_reg        <= 31'd0;
                            halted_reg     <= 1'b0;
                        end
                        else
                        begin
                            phase_snap_reg <= phase_reg;
                            mlen_snap_reg  <= mlen_reg;
                            olog_snap_reg  <= olog_reg;
                        end
                        if (!hlt && p < out_length_reg)
                        begin
                            buf_reg      <= b | (32'(compressed_byte) << c);
                            buf_snap_reg <= b | (32'(compressed_byte) << c);
                            cnt_reg      <= c + 5'd8;
                            cnt_snap_reg <= c + 5'd8;
                            pos_snap_reg <= p;
                            err_reg      <= lz77d_pkg::ERR_NONE;
                            dry_reg      <= 1'b1;
                            state_reg    <= S_DEC;
                        end
                        else if (stream_start)
                        begin
                            buf_reg <= 32'd0;
                            cnt_reg <= 5'd0;
                        end
                    end
                end

                S_DEC:
                begin
                    if (!can_step)
                    begin
                        if (dry_reg)
                        begin
                            // first pass over: remember the end state, rewind
                            done_reg  <= (pos_reg >= out_length_reg);
                            dry_reg   <= 1'b0;
                            err_reg   <= lz77d_pkg::ERR_NONE;
                            buf_reg   <= buf_snap_reg;
                            cnt_reg   <= cnt_snap_reg;
                            phase_reg <= phase_snap_reg;
                            mlen_reg  <= mlen_snap_reg;
                            olog_reg  <= olog_snap_reg;
                            pos_reg   <= pos_snap_reg;
                        end
                        else
                        begin
                            state_reg <= S_FINAL;
                        end
                    end
                    else if (!dry_reg && phase_reg == PH_LIT && acc_full)
                    begin
                        // lanes full and another byte follows: send them first
                        ret_reg   <= S_DEC;
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        buf_reg <= buf_reg >> need;
                        cnt_reg <= cnt_reg - need;
                        unique case (phase_reg)
                            PH_FLAG:
                            begin
                                phase_reg <= field_v[0] ? PH_PRE0 : PH_LIT;
                            end
                            PH_LIT:
                            begin
                                pos_reg   <= pos_reg + 31'd1;
                                phase_reg <= PH_FLAG;
                                if (!dry_reg)
                                begin
                                    acc_reg[acc_cnt_reg[3:0]] <= field_v[7:0];
                                    acc_cnt_reg <= acc_cnt_reg + 5'd1;
                                end
                            end
                            PH_PRE0, PH_PRE1, PH_PRE2, PH_PRE3, PH_PRE4:
                            begin
                                if (field_v[0])
                                begin
                                    olog_reg  <= 5'(stage);
                                    phase_reg <= PH_LENBITS;
                                end
                                else if (phase_reg == PH_PRE4)
                                begin
                                    olog_reg  <= 5'd5;
                                    phase_reg <= PH_LENBITS;
                                end
                                else
                                begin
                                    phase_reg <= phase_t'(phase_reg + 4'd1);
                                end
                            end
                            PH_LENBITS:
                            begin
                                mlen_reg  <= 10'(field_v) + lz77d_pkg::len_base(len_cls);
                                phase_reg <= PH_SLOT;
                            end
                            PH_SLOT:
                            begin
                                olog_reg  <= 5'(field_v) + 5'(SLOT_BASE);
                                phase_reg <= PH_OFFSET;
                            end
                            default:
                            begin
                                phase_reg <= PH_FLAG;
                                if (32'(dist_v) > pos_ext)
                                begin
                                    err_reg <= lz77d_pkg::ERR_DIST;
                                end
                                else if (pos_ext + 32'(total) > {1'b0, out_length_reg})
                                begin
                                    err_reg <= lz77d_pkg::ERR_OVERRUN;
                                end
                                else if (dry_reg)
                                begin
                                    pos_reg <= pos_reg + 31'(total);
                                end
                                else
                                begin
                                    copy_left_reg <= total;
                                    dist_reg      <= dist_v;
                                    state_reg     <= S_COPY_RD;
                                end
                            end
                        endcase
                    end
                end

                S_COPY_RD:
                begin
                    // full lanes go out before the next byte is read
                    if (acc_full)
                    begin
                        ret_reg   <= S_COPY_RD;
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        state_reg <= S_COPY_WR;
                    end
                end

                S_COPY_WR:
                begin
                    // byte read last cycle is written back and appended
                    acc_reg[acc_cnt_reg[3:0]] <= rd_data_reg;
                    acc_cnt_reg   <= acc_cnt_reg + 5'd1;
                    pos_reg       <= pos_reg + 31'd1;
                    copy_left_reg <= copy_left_reg - 11'd1;
                    state_reg     <= (copy_left_reg > 11'd1) ? S_COPY_RD : S_DEC;
                end

                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        olast_reg     <= 1'b0;
                        oerr_reg      <= lz77d_pkg::ERR_NONE;
                        acc_cnt_reg   <= 5'd0;
                        state_reg     <= ret_reg;
                    end
                end

                S_FINAL:
                begin
                    if (err_reg != lz77d_pkg::ERR_NONE)
                    begin
                        halted_reg <= 1'b1;
                    end
                    if (acc_cnt_reg == 5'd0)
                    begin
                        state_reg <= (err_reg != lz77d_pkg::ERR_NONE) ? S_ERR_OUT : S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        olast_reg     <= (err_reg == lz77d_pkg::ERR_NONE);
                        oerr_reg      <= lz77d_pkg::ERR_NONE;
                        acc_cnt_reg   <= 5'd0;
                        state_reg <= (err_reg != lz77d_pkg::ERR_NONE) ? S_ERR_OUT : S_IDLE;
                    end
                end

                S_ERR_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        olast_reg     <= 1'b1;
                        oerr_reg      <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload: lanes beyond the count read as zero
    always_ff @(posedge clk)
    begin
        if (load_any)
        begin
            lo_reg    <= 64'd0;
            hi_reg    <= 64'd0;
            oc_reg    <= 5'd0;
            odone_reg <= done_reg;
            if (load_lanes)
            begin
                oc_reg <= acc_cnt_reg;
                for (int l = 0; l < 8; l++)
                begin
                    lo_reg[8*l +: 8] <= (5'(l) < acc_cnt_reg) ? acc_reg[l] : 8'd0;
                    hi_reg[8*l +: 8] <= (5'(l + 8) < acc_cnt_reg) ? acc_reg[l + 8] : 8'd0;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign bytes_low   = lo_reg;
    assign bytes_high  = hi_reg;
    assign byte_count  = oc_reg;
    assign last_of_run = olast_reg;
    assign stream_done = odone_reg;
    assign error_code  = oerr_reg;

    // Checks
    a_idle_acc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> acc_cnt_reg == 5'd0)
        else $error("lane accumulator not empty between bytes");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= 5'(LANE_BYTES))
        else $error("lane accumulator overfilled");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && oerr_reg != lz77d_pkg::ERR_NONE |-> olast_reg && oc_reg == 5'd0)
        else $error("error result carries bytes or is not last");

    a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY_RD || state_reg == S_COPY_WR |-> copy_left_reg != 11'd0)
        else $error("copy running with no bytes left");

endmodule

// ===== verif/tb_lz77_bitstream_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz77_bitstream_decompressor_top
// Self-checking bench for the LZ77 bit-stream decompressor. Compressed
// streams are built token by token (literals, matches of every length class,
// bad distances, overruns, plain noise), sent one byte per transfer, and the
// decoded lanes are checked against a behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_lz77_bitstream_decompressor_top;

    localparam int WBITS     = lz77d_pkg::WINDOW_BITS_DEF;
    localparam int LANES     = lz77d_pkg::LANE_BYTES_DEF;
    localparam int SLOT_BASE = WBITS - 16;
    localparam int MAX_TOK   = 566;
    localparam int WDOG_MAX  = 30000;

    typedef enum int {
        PH_FLAG = 0, PH_LIT = 1, PH_PRE = 2, PH_LEN = 7, PH_SLOT = 8, PH_OFF = 9
    } phase_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } byte_item_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
        logic        done;
        logic [1:0]  err;
    } lane_t;

    logic        clk, rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [7:0]  compressed_byte;
    logic        stream_start;
    logic [63:0] bytes_low, bytes_high;
    logic [4:0]  byte_count;
    logic        last_of_run, stream_done;
    logic [1:0]  error_code;

    lz77_bitstream_decompressor_top dut (.*);

    byte_item_t   pend_bytes[$];
    lane_t        exp_lanes[$];
    bit           bitq[$];
    bit           in_acc;
    int           mismatches;
    int           watchdog;
    int           snd_idle, rcv_idle;

    // decoder state
    logic [30:0]  m_olen, m_pos;
    logic [31:0]  m_buf;
    int           m_cnt, m_mlen, m_log;
    phase_t       m_phase;
    bit           m_halt;
    logic [7:0]   m_hist[int unsigned];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int len_base_of(input int c);
        int t[6] = '{0, 4, 8, 12, 20, 52};
        return t[c];
    endfunction

    function automatic int len_width_of(input int c);
        int t[6] = '{2, 2, 2, 3, 5, 9};
        return t[c];
    endfunction

    // ------------------------------------------------------------------
    // Decoder: one compressed byte in, expected lanes pushed
    // ------------------------------------------------------------------
    task automatic decode_byte(input logic [7:0] b, input logic st);
        logic [7:0] prod[$];
        logic [1:0] err;
        int         need, v, cls;
        longint     mdist, total, off;
        lane_t      r;
        int         n0;
        err = lz77d_pkg::ERR_NONE;
        if (st)
        begin
            m_buf = '0; m_cnt = 0; m_phase = PH_FLAG; m_mlen = 0; m_log = 0;
            m_pos = '0; m_halt = 1'b0;
        end
        if (m_halt || m_pos >= m_olen) return;
        m_buf = m_buf | (32'(b) << m_cnt);
        m_cnt += 8;
        while (m_pos < m_olen && err == lz77d_pkg::ERR_NONE)
        begin
            cls = (m_log < 6) ? m_log : 5;
            case (m_phase)
                PH_FLAG: need = 1;
                PH_LIT:  need = 8;
                PH_LEN:  need = len_width_of(cls);
                PH_SLOT: need = lz77d_pkg::SLOT_BITS;
                PH_OFF:  need = (m_log > SLOT_BASE) ? m_log : SLOT_BASE + 1;
                default: need = 1;
            endcase
            if (m_cnt < need) break;
            v = int'(m_buf & ((32'd1 << need) - 1));
            m_buf = m_buf >> need;
            m_cnt -= need;
            if (m_phase == PH_FLAG)
                m_phase = v ? PH_PRE : PH_LIT;
            else if (m_phase == PH_LIT)
            begin
                m_hist[m_pos & ((1 << WBITS) - 1)] = v[7:0];
                prod.push_back(v[7:0]);
                m_pos = m_pos + 1;
                m_phase = PH_FLAG;
            end
            else if (m_phase >= PH_PRE && m_phase < PH_LEN)
            begin
                if (v != 0)
                begin
                    m_log = m_phase - PH_PRE; m_phase = PH_LEN;
                end
                else if (m_phase == PH_PRE + 4)
                begin
                    m_log = 5; m_phase = PH_LEN;
                end
                else
                    m_phase = phase_t'(m_phase + 1);
            end
            else if (m_phase == PH_LEN)
            begin
                m_mlen = (v + len_base_of(cls)) & 10'h3ff;
                m_phase = PH_SLOT;
            end
            else if (m_phase == PH_SLOT)
            begin
                m_log = v + SLOT_BASE;
                m_phase = PH_OFF;
            end
            else
            begin
                off = v;
                if (m_log > SLOT_BASE) off += longint'(1) << m_log;
                mdist = off + 1;
                total = m_mlen + lz77d_pkg::MIN_MATCH;
                m_phase = PH_FLAG;
                if (mdist > m_pos) err = lz77d_pkg::ERR_DIST;
                else if (longint'(m_pos) + total > m_olen) err = lz77d_pkg::ERR_OVERRUN;
                else
                    for (longint k = 0; k < total; k++)
                    begin
                        logic [7:0] cb;
                        cb = m_hist[(m_pos - mdist) & ((1 << WBITS) - 1)];
                        m_hist[m_pos & ((1 << WBITS) - 1)] = cb;
                        prod.push_back(cb);
                        m_pos = m_pos + 1;
                    end
            end
        end
        if (err != lz77d_pkg::ERR_NONE) m_halt = 1'b1;
        n0 = exp_lanes.size();
        for (int i = 0; i < prod.size(); i += LANES)
        begin
            r = '{lo: '0, hi: '0, cnt: '0, last: 1'b0, done: 1'b0, err: lz77d_pkg::ERR_NONE};
            for (int k = 0; k < LANES && i + k < prod.size(); k++)
            begin
                if (k < 8) r.lo[8*k +: 8] = prod[i+k];
                else r.hi[8*(k-8) +: 8] = prod[i+k];
                r.cnt++;
            end
            exp_lanes.push_back(r);
        end
        if (err != lz77d_pkg::ERR_NONE)
        begin
            r = '{lo: '0, hi: '0, cnt: '0, last: 1'b0, done: 1'b0, err: err};
            exp_lanes.push_back(r);
        end
        for (int k = n0; k < exp_lanes.size(); k++)
            exp_lanes[k].done = (m_pos >= m_olen);
        if (exp_lanes.size() > n0) exp_lanes[exp_lanes.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Input driver: accept at rising edge, drive at falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(compressed_byte, stream_start);
            void'(pend_bytes.pop_front());
            in_acc = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_acc)
            begin
                in_acc = 1'b0;
                if (pend_bytes.size() > 0 && $urandom_range(99) >= snd_idle)
                begin
                    in_valid        <= 1'b1;
                    compressed_byte <= pend_bytes[0].data;
                    stream_start    <= pend_bytes[0].start;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lane_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_lanes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: cnt=%0d err=%0d", byte_count, error_code);
            end
            else
            begin
                e = exp_lanes.pop_front();
                if (e.lo !== bytes_low || e.hi !== bytes_high || e.cnt !== byte_count ||
                    e.last !== last_of_run || e.done !== stream_done || e.err !== error_code)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp lo=%h hi=%h cnt=%0d last=%b done=%b err=%0d",
                                 e.lo, e.hi, e.cnt, e.last, e.done, e.err);
                        $display("         got lo=%h hi=%h cnt=%0d last=%b done=%b err=%0d",
                                 bytes_low, bytes_high, byte_count, last_of_run,
                                 stream_done, error_code);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    task automatic put_bits(input int val, input int n);
        for (int i = 0; i < n; i++) bitq.push_back(val[i]);
    endtask

    task automatic tok_lit(input logic [7:0] v);
        put_bits(0, 1);
        put_bits(v, 8);
    endtask

    task automatic tok_match(input int total, input int d);
        int m, c, off, lg;
        m = total - lz77d_pkg::MIN_MATCH;
        c = (m < 4) ? 0 : (m < 8) ? 1 : (m < 12) ? 2 : (m < 20) ? 3 : (m < 52) ? 4 : 5;
        put_bits(1, 1);
        if (c < 5) put_bits(1 << c, c + 1);
        else put_bits(0, 5);
        put_bits(m - len_base_of(c), len_width_of(c));
        off = d - 1;
        if (off < (1 << (SLOT_BASE + 1)))
        begin
            put_bits(0, lz77d_pkg::SLOT_BITS);
            put_bits(off, SLOT_BASE + 1);
        end
        else
        begin
            lg = $clog2(off + 1) - 1;
            put_bits(lg - SLOT_BASE, lz77d_pkg::SLOT_BITS);
            put_bits(off - (1 << lg), lg);
        end
    endtask

    // pack queued bits into bytes; padding bits are random
    task automatic flush_bits(input bit first_start, input int extra);
        byte_item_t it;
        bit         st;
        st = first_start;
        while (bitq.size() > 0)
        begin
            it.data = 8'($urandom);
            for (int i = 0; i < 8 && bitq.size() > 0; i++) it.data[i] = bitq.pop_front();
            it.start = st;
            st = 1'b0;
            pend_bytes.push_back(it);
        end
        for (int i = 0; i < extra; i++)
        begin
            it.data = 8'($urandom);
            it.start = 1'b0;
            pend_bytes.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (pend_bytes.size() > 0 || exp_lanes.size() > 0 || in_valid || in_stall)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_out_length(input logic [30:0] v);
        wait_idle();
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(lz77d_pkg::REG_OUT_LENGTH) << 2;
        pwdata <= {1'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        m_olen = v;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // kind: 0 clean, 1 bad distance, 2 overrun
    task automatic rand_stream(input int olen, input int kind);
        int p, rem, total, d, c, lo_t, trig;
        p = 0;
        trig = $urandom_range(0, olen);
        while (p < olen)
        begin
            rem = olen - p;
            if (kind != 0 && p >= trig)
            begin
                if (kind == 2 && p > 0 && rem + 1 <= MAX_TOK)
                begin
                    lo_t = (rem + 1 > 3) ? rem + 1 : 3;
                    tok_match($urandom_range(lo_t, MAX_TOK), $urandom_range(1, p));
                end
                else
                begin
                    d = p + 1 + $urandom_range(0, (1 << $urandom_range(0, 20)) - 1);
                    if (d > (1 << WBITS)) d = 1 << WBITS;
                    tok_match($urandom_range(3, MAX_TOK), d);
                end
                break;
            end
            if (p == 0 || rem < 3 || $urandom_range(99) < 45)
            begin
                tok_lit(8'($urandom));
                p++;
            end
            else
            begin
                c = $urandom_range(0, 5);
                total = lz77d_pkg::MIN_MATCH + len_base_of(c) +
                        $urandom_range(0, (1 << len_width_of(c)) - 1);
                if (total > rem) total = $urandom_range(3, rem);
                case ($urandom_range(2))
                    0: d = p;
                    1: d = $urandom_range(1, (p < 64) ? p : 64);
                    default: d = $urandom_range(1, p);
                endcase
                tok_match(total, d);
                p += total;
            end
        end
        flush_bits(1'b1, $urandom_range(0, 2));
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int sent, kind, olen;
        byte_item_t it;
        rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; in_valid = 1'b0; compressed_byte = '0;
        stream_start = 1'b0; out_stall = 1'b0; in_acc = 1'b0;
        mismatches = 0; watchdog = 0; snd_idle = 38; rcv_idle = 57;
        m_olen = '0; m_pos = '0; m_buf = '0; m_cnt = 0; m_phase = PH_FLAG;
        m_mlen = 0; m_log = 0; m_halt = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length: every byte dropped
        set_out_length('0);
        tok_lit(8'h3c);
        flush_bits(1'b1, 1);
        // extreme literals and the longest match
        set_out_length(31'd570);
        tok_lit(8'h00); tok_lit(8'hff); tok_match(MAX_TOK, 2); tok_lit(8'h80); tok_lit(8'h01);
        flush_bits(1'b1, 1);
        // one match of each length class 0 to 4
        set_out_length(31'd64);
        tok_lit(8'h11); tok_lit(8'h22); tok_lit(8'h44); tok_lit(8'h88);
        tok_match(3, 1); tok_match(7, 4); tok_match(11, 7); tok_match(15, 30);
        tok_match(23, 60); tok_lit(8'h55);
        flush_bits(1'b1, 0);
        // distance beyond produced data, then halted bytes dropped
        set_out_length(31'd50);
        tok_lit(8'h7e); tok_match(3, 5);
        flush_bits(1'b1, 2);
        // match overruns the length
        set_out_length(31'd5);
        tok_lit(8'h01); tok_lit(8'h02); tok_match(4, 1);
        flush_bits(1'b1, 0);
        // length raised mid stream: decoding resumes from buffered bits
        set_out_length(31'd2);
        tok_lit(8'ha5); tok_lit(8'h5a); tok_lit(8'hc3); tok_lit(8'h3c);
        flush_bits(1'b1, 0);
        set_out_length(31'd4);
        it.data = 8'($urandom); it.start = 1'b0;
        pend_bytes.push_back(it);
        // largest length: never completes
        set_out_length(31'h7fffffff);
        tok_lit(8'h96);
        flush_bits(1'b1, 2);

        // random part
        sent = 0;
        while (sent < 300)
        begin
            if (sent < 100)
            begin
                snd_idle = 38; rcv_idle = 57;
            end
            else if (sent < 200)
            begin
                snd_idle = 57; rcv_idle = 38;
            end
            else
            begin
                snd_idle = 0; rcv_idle = 0;
            end
            kind = $urandom_range(9);
            olen = ($urandom_range(9) == 0) ? $urandom_range(300, 1200)
                                            : $urandom_range(8, 120);
            if (kind == 9)
            begin
                // noise bytes
                set_out_length(($urandom_range(1) == 0) ? 31'($urandom)
                                                        : 31'($urandom_range(1, 40)));
                for (int i = $urandom_range(1, 6); i > 0; i--)
                begin
                    it.data = 8'($urandom);
                    it.start = (pend_bytes.size() == 0);
                    pend_bytes.push_back(it);
                end
            end
            else
            begin
                set_out_length(31'(olen));
                rand_stream(olen, (kind < 7) ? 0 : (kind == 7) ? 1 : 2);
            end
            sent += pend_bytes.size();
        end

        wait_idle();
        repeat (1200) @(posedge clk);
        if (mismatches == 0 && exp_lanes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
